// File: rtl/core/sliding_window_median_macros.svh
// assertion macros for the sliding window median core
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define SWM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sliding_window_median: assertion failed");
// next-cycle implication, checked out of reset
`define SWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sliding_window_median: assertion failed");
`else
`define SWM_ASSERT_NOW(label, ante, cons)
`define SWM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/swm_pkg.sv
package swm_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // window size register
    localparam int              WSIZE_BITS  = 7;
    localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 7'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_PICK
    } swm_state_t;

    // control broadcast to every cell of the sorted chain
    typedef struct packed {
        logic shift;    // cells take their next value
        logic replace;  // window full: leaving sample is dropped
    } swm_ctrl_t;

endpackage

// File: rtl/core/swm_ring.sv
module swm_ring #(
    parameter int DEPTH = swm_pkg::MAX_WINDOW_DEF,
    parameter int WIDTH = swm_pkg::SAMPLE_BITS_DEF,
    parameter int AW    = 6
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic signed [WIDTH-1:0] wr_data,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr,
    output logic signed [WIDTH-1:0] rd_data
);
    import swm_pkg::*;

    logic signed [WIDTH-1:0] mem [DEPTH];
    logic signed [WIDTH-1:0] rd_data_reg;

    // read returns the old contents when both ports hit the same slot
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/swm_cell.sv
module swm_cell #(
    parameter int WIDTH = swm_pkg::SAMPLE_BITS_DEF,
    parameter int CW    = 7,
    parameter int INDEX = 0
) (
    input  logic                    clk,
    input  swm_pkg::swm_ctrl_t      ctrl,
    input  logic [CW-1:0]           count,     // entries held after removal
    input  logic signed [WIDTH-1:0] new_val,
    input  logic signed [WIDTH-1:0] old_val,
    input  logic signed [WIDTH-1:0] left_u,
    input  logic                    left_le,
    input  logic signed [WIDTH-1:0] right_v,
    output logic signed [WIDTH-1:0] v,
    output logic signed [WIDTH-1:0] u,
    output logic                    le
);
    import swm_pkg::*;

    logic signed [WIDTH-1:0] v_reg;
    logic signed [WIDTH-1:0] v_next;
    logic                    ge;

    always_comb
    begin
        // at or past the leaving sample: close the gap from the right
        ge = ctrl.replace && (v_reg >= old_val);
        u  = ge ? right_v : v_reg;
        // an occupied cell stays in place if not above the new sample
        le = (count > CW'(INDEX)) && (u <= new_val);
        if (le)
        begin
            v_next = u;
        end
        else if (left_le)
        begin
            v_next = new_val;
        end
        else
        begin
            v_next = left_u;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            v_reg <= v_next;
        end
    end

    assign v = v_reg;

endmodule

// File: rtl/core/sliding_window_median.sv
// sliding window lower median, one signed sample per word
// each accepted word passes the chain shift step and then the pick of the median
// cell; a result word is emitted only once the window is full, and the next
// word is taken in the pick step; a stalled result holds the block in the pick step
// reset: control cleared, window empty, window size 3; sample stores undefined
`include "sliding_window_median_macros.svh"

module sliding_window_median #(
    parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [swm_pkg::WSIZE_BITS-1:0]    cfg_wr_data,
    // input words
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    input  logic                              start_new,
    // result words
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [SAMPLE_BITS-1:0]     median
);
    import swm_pkg::*;

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    // control state
    swm_state_t              state_reg, state_next;
    logic [WSIZE_BITS-1:0]   window_size_reg;
    logic [CW-1:0]           fill_count_reg, fill_count_next;
    logic [AW-1:0]           oldest_ptr_reg, oldest_ptr_next;
    logic                    out_valid_reg, out_valid_next;

    // word in flight
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [CW-1:0]                 count_reg, count_next;
    logic                          replace_reg, replace_next;
    logic                          emit_reg, emit_next;
    logic signed [SAMPLE_BITS-1:0] median_reg;

    logic                    in_accept;
    logic                    pick_done;
    logic [CW-1:0]           w_eff;
    logic [CW-1:0]           w_minus1;
    logic [AW-1:0]           mid_idx;
    logic [CW-1:0]           fill_eff;
    logic [AW-1:0]           ptr_eff;
    logic [CW:0]             slot_sum;
    logic [CW-1:0]           slot_plus;
    logic [AW-1:0]           slot;

    logic signed [SAMPLE_BITS-1:0] old_sample;
    swm_ctrl_t                     ctrl;

    logic signed [SAMPLE_BITS-1:0] cell_v [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] cell_u [MAX_WINDOW];
    logic                          cell_le [MAX_WINDOW];

    // effective window: zero acts as one, large sizes saturate
    always_comb
    begin
        priority if (window_size_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (32'(window_size_reg) > 32'(MAX_WINDOW))
        begin
            w_eff = CW'(MAX_WINDOW);
        end
        else
        begin
            w_eff = CW'(window_size_reg);
        end
        w_minus1 = w_eff - CW'(1);
        mid_idx  = AW'(w_minus1 >> 1);
    end

    // handshake
    assign pick_done = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == S_IDLE) || ((state_reg == S_PICK) && pick_done));
    assign in_accept = in_valid && !in_stall;

    // window bookkeeping for the word at the input
    always_comb
    begin
        fill_eff     = start_new ? '0 : fill_count_reg;
        ptr_eff      = start_new ? '0 : oldest_ptr_reg;
        replace_next = (fill_eff == w_eff);

        // ring slot of a new word while filling
        slot_sum = {1'b0, CW'(ptr_eff)} + {1'b0, fill_eff};
        if (slot_sum >= {1'b0, w_eff})
        begin
            slot_sum = slot_sum - {1'b0, w_eff};
        end

        if (replace_next)
        begin
            // full: overwrite the oldest slot and advance past it
            slot      = ptr_eff;
            slot_plus = CW'(ptr_eff) + CW'(1);
            oldest_ptr_next = (slot_plus == w_eff) ? '0 : AW'(slot_plus);
            fill_count_next = w_eff;
            count_next      = w_minus1;
        end
        else
        begin
            slot      = AW'(slot_sum);
            slot_plus = '0;
            oldest_ptr_next = ptr_eff;
            fill_count_next = fill_eff + CW'(1);
            count_next      = fill_eff;
        end
        emit_next = (fill_count_next == w_eff);
    end

    // arrival order ring: old sample read as the new one is written
    swm_ring #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_BITS),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (slot),
        .wr_data (sample),
        .rd_en   (in_accept),
        .rd_addr (slot),
        .rd_data (old_sample)
    );

    // sorted chain: each cell looks at its neighbors and takes its new value
    always_comb
    begin
        ctrl.shift   = (state_reg == S_SHIFT);
        ctrl.replace = replace_reg;
    end

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic signed [SAMPLE_BITS-1:0] left_u;
        logic                          left_le;
        logic signed [SAMPLE_BITS-1:0] right_v;

        if (i == 0)
        begin : g_head
            assign left_u  = '0;
            assign left_le = 1'b1;   // nothing below the head cell
        end
        else
        begin : g_body
            assign left_u  = cell_u[i-1];
            assign left_le = cell_le[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_tail
            assign right_v = cell_v[i];
        end
        else
        begin : g_mid
            assign right_v = cell_v[i+1];
        end

        swm_cell #(
            .WIDTH (SAMPLE_BITS),
            .CW    (CW),
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .count   (count_reg),
            .new_val (sample_reg),
            .old_val (old_sample),
            .left_u  (left_u),
            .left_le (left_le),
            .right_v (right_v),
            .v       (cell_v[i]),
            .u       (cell_u[i]),
            .le      (cell_le[i])
        );
    end

    // sequencer: accept, shift the chain, pick the median cell
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (pick_done)
                begin
                    if (emit_reg)
                    begin
                        out_valid_next = 1'b1;
                    end
                    state_next = in_accept ? S_SHIFT : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_size_reg <= WSIZE_RESET;
            fill_count_reg  <= '0;
            oldest_ptr_reg  <= '0;
            out_valid_reg   <= 1'b0;
            replace_reg     <= 1'b0;
            emit_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                // new size empties the window
                window_size_reg <= cfg_wr_data;
                fill_count_reg  <= '0;
                oldest_ptr_reg  <= '0;
            end
            else if (in_accept)
            begin
                fill_count_reg <= fill_count_next;
                oldest_ptr_reg <= oldest_ptr_next;
            end
            if (in_accept)
            begin
                replace_reg <= replace_next;
                emit_reg    <= emit_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample;
            count_reg  <= count_next;
        end
        if ((state_reg == S_PICK) && pick_done && emit_reg)
        begin
            median_reg <= cell_v[mid_idx];
        end
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;

    `SWM_ASSERT_NOW(a_accept_state, in_accept, (state_reg == S_IDLE) || (state_reg == S_PICK))
    `SWM_ASSERT_NOW(a_fill_bound, state_reg == S_IDLE, fill_count_reg <= w_eff)
    `SWM_ASSERT_NEXT(a_shift_then_pick, state_reg == S_SHIFT, state_reg == S_PICK)
    `SWM_ASSERT_NOW(a_emit_from_pick, $rose(out_valid_reg), $past(state_reg) == S_PICK)

endmodule
